@@ src/button_debounce_click_hold_unit_assert.svh @@
// Assertion macros for the button debounce click/hold unit.
// Included by the top level; no other dependencies.
`ifndef BUTTON_DEBOUNCE_CLICK_HOLD_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_HOLD_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BDCH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bdch_pkg.sv @@
// Package for the button debounce click/hold unit: widths, register map,
// reset values, config struct and the lane-to-merge result struct.
`default_nettype none

package bdch_pkg;

   localparam int PIN_WIDTH      = 16;
   localparam int CFG_WIDTH      = 16;
   localparam int BUTTON_COUNT   = 16;
   localparam int TIMER_BITS     = 16;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;

   // register indexes, byte address is 4 * index
   localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
   localparam logic [1:0] REG_CLICK_MAX = 2'd1;
   localparam logic [1:0] REG_HOLD      = 2'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET  = 16'd20;
   localparam logic [CFG_WIDTH-1:0] CLICK_MAX_RESET = 16'd500;
   localparam logic [CFG_WIDTH-1:0] HOLD_RESET      = 16'd1000;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] click_max_ms;
      logic [CFG_WIDTH-1:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      logic pressed;
      logic click;
      logic hold;
   } lane_result_type;

endpackage

`default_nettype wire

@@ src/bdch_req_if.sv @@
// Input channel of the button debounce click/hold unit.
// Depends on bdch_pkg for the pin word width.
`default_nettype none

interface bdch_req_if;
   logic                           valid;
   logic                           ready;
   logic [bdch_pkg::PIN_WIDTH-1:0] pin_levels;
   logic                           fresh;

   modport source (output valid, output pin_levels, output fresh, input ready);
   modport sink   (input valid, input pin_levels, input fresh, output ready);
endinterface

`default_nettype wire

@@ src/bdch_rsp_if.sv @@
// Result channel of the button debounce click/hold unit.
// Depends on bdch_pkg for the mask width.
`default_nettype none

interface bdch_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bdch_pkg::PIN_WIDTH-1:0] pressed_mask;
   logic [bdch_pkg::PIN_WIDTH-1:0] click_pulses;
   logic [bdch_pkg::PIN_WIDTH-1:0] hold_pulses;

   modport source (output valid, output pressed_mask, output click_pulses,
                   output hold_pulses, input ready);
   modport sink   (input valid, input pressed_mask, input click_pulses,
                   input hold_pulses, output ready);
endinterface

`default_nettype wire

@@ src/button_debounce_click_hold_unit.sv @@
// A result item is offered in the cycle after its tick item is accepted.
// Throughput: one item per cycle; every button lane updates in the same cycle,
// and the single output register stalls intake only while its item waits.
// Reset (synchronous, active high): all buttons released, timers and hold
// locks cleared, registers at 20 / 500 / 1000 ms, output register empty.
`default_nettype none

`include "button_debounce_click_hold_unit_assert.svh"

module button_debounce_click_hold_unit #(
   parameter int BUTTON_COUNT = bdch_pkg::BUTTON_COUNT,
   parameter int TIMER_BITS   = bdch_pkg::TIMER_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   bdch_req_if.sink                                req_ch,
   bdch_rsp_if.source                              rsp_ch,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [bdch_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [bdch_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [bdch_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                    pready
);

   localparam int CW = bdch_pkg::CFG_WIDTH;

   bdch_pkg::cfg_type         cfg_ff, cfg_in;
   bdch_pkg::lane_result_type lanes [BUTTON_COUNT];
   logic                      step;
   logic                      slot_free;
   logic                      csr_write;
   logic [1:0]                csr_index;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            bdch_pkg::REG_DEBOUNCE:  cfg_in.debounce_ms  = pwdata[CW-1:0];
            bdch_pkg::REG_CLICK_MAX: cfg_in.click_max_ms = pwdata[CW-1:0];
            bdch_pkg::REG_HOLD:      cfg_in.hold_ms      = pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bdch_pkg::REG_DEBOUNCE:  prdata = bdch_pkg::CSR_DATA_BITS'(cfg_ff.debounce_ms);
         bdch_pkg::REG_CLICK_MAX: prdata = bdch_pkg::CSR_DATA_BITS'(cfg_ff.click_max_ms);
         bdch_pkg::REG_HOLD:      prdata = bdch_pkg::CSR_DATA_BITS'(cfg_ff.hold_ms);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= bdch_pkg::DEBOUNCE_RESET;
         cfg_ff.click_max_ms <= bdch_pkg::CLICK_MAX_RESET;
         cfg_ff.hold_ms      <= bdch_pkg::HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // item intake
   assign req_ch.ready = slot_free;
   assign step         = req_ch.valid && slot_free;

   for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
      bdch_lane #(
         .TIMER_BITS (TIMER_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .pin_level (req_ch.pin_levels[g]),
         .fresh     (req_ch.fresh),
         .cfg       (cfg_ff),
         .result    (lanes[g])
      );
   end

   bdch_merge #(
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .lanes     (lanes),
      .slot_free (slot_free),
      .rsp_ch    (rsp_ch)
   );

   `BDCH_ASSERT_NEXT(a_accept_gives_result, clock, reset,
      req_ch.valid && req_ch.ready, rsp_ch.valid, "accepted item produced no result")
   `BDCH_ASSERT_NOW(a_stall_blocks_intake, clock, reset,
      rsp_ch.valid && !rsp_ch.ready, !req_ch.ready, "intake open while result stalled")
   `BDCH_ASSERT_NOW(a_click_is_release, clock, reset,
      rsp_ch.valid, (rsp_ch.click_pulses & rsp_ch.pressed_mask) == '0,
      "click pulse on a button still pressed")
   `BDCH_ASSERT_NOW(a_hold_is_pressed, clock, reset,
      rsp_ch.valid, (rsp_ch.hold_pulses & ~rsp_ch.pressed_mask) == '0,
      "hold pulse on a released button")

endmodule

`default_nettype wire

@@ src/bdch_lane.sv @@
// One button lane: debounced state, saturating elapsed timer and hold lock.
// Depends on bdch_pkg for the config and result structs.
`default_nettype none

module bdch_lane #(
   parameter int TIMER_BITS = bdch_pkg::TIMER_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic                       pin_level,
   input  wire logic                       fresh,
   input  wire bdch_pkg::cfg_type          cfg,
   output bdch_pkg::lane_result_type       result
);

   localparam int CMP_BITS = (TIMER_BITS > bdch_pkg::CFG_WIDTH) ?
                             TIMER_BITS : bdch_pkg::CFG_WIDTH;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   logic                  pressed_ff, pressed_in;
   logic                  locked_ff,  locked_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;

   logic [TIMER_BITS-1:0] elapsed_inc;
   logic [CMP_BITS-1:0]   inc_wide;
   logic                  now_down;
   logic                  change;
   logic                  click;
   logic                  hold;

   always_comb begin
      elapsed_inc = (elapsed_ff == TIMER_MAX) ? elapsed_ff
                                              : elapsed_ff + TIMER_BITS'(1);
      inc_wide    = CMP_BITS'(elapsed_inc);
      now_down    = ~pin_level;
      change      = fresh && (now_down != pressed_ff) &&
                    (inc_wide > CMP_BITS'(cfg.debounce_ms));

      pressed_in = pressed_ff;
      locked_in  = locked_ff;
      elapsed_in = elapsed_inc;
      click      = 1'b0;
      if (change) begin
         pressed_in = now_down;
         elapsed_in = '0;
         if (!now_down) begin
            locked_in = 1'b0;
            click     = inc_wide < CMP_BITS'(cfg.click_max_ms);
         end
      end

      // hold check runs on the updated state
      hold = pressed_in && !locked_in &&
             (CMP_BITS'(elapsed_in) > CMP_BITS'(cfg.hold_ms));
      if (hold) begin
         locked_in = 1'b1;
      end

      result.pressed = pressed_in;
      result.click   = click;
      result.hold    = hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         locked_ff  <= 1'b0;
         elapsed_ff <= '0;
      end else if (step) begin
         pressed_ff <= pressed_in;
         locked_ff  <= locked_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

@@ src/bdch_merge.sv @@
// Merge stage: packs the lane results into masks and holds them in the
// output register. Depends on bdch_pkg and bdch_rsp_if.
`default_nettype none

module bdch_merge #(
   parameter int BUTTON_COUNT = bdch_pkg::BUTTON_COUNT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire bdch_pkg::lane_result_type lanes [BUTTON_COUNT],
   output logic                           slot_free,
   bdch_rsp_if.source                     rsp_ch
);

   localparam int W = bdch_pkg::PIN_WIDTH;

   logic         valid_ff, valid_in;
   logic [W-1:0] pressed_ff, pressed_in;
   logic [W-1:0] click_ff,   click_in;
   logic [W-1:0] hold_ff,    hold_in;

   always_comb begin
      pressed_in = '0;
      click_in   = '0;
      hold_in    = '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         pressed_in[i] = lanes[i].pressed;
         click_in[i]   = lanes[i].click;
         hold_in[i]    = lanes[i].hold;
      end
      valid_in  = step || (valid_ff && !rsp_ch.ready);
      slot_free = !valid_ff || rsp_ch.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pressed_ff <= pressed_in;
         click_ff   <= click_in;
         hold_ff    <= hold_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.pressed_mask = pressed_ff;
   assign rsp_ch.click_pulses = click_ff;
   assign rsp_ch.hold_pulses  = hold_ff;

endmodule

`default_nettype wire
